// ===== design/smfd_pkg.sv =====
package smfd_pkg;

   localparam int MSG_DEPTH_DEFAULT = 32;
   localparam int CMD_DEPTH_DEFAULT = 32;

   // input command codes
   localparam logic [1:0] CMD_ADD_MSG  = 2'd0;
   localparam logic [1:0] CMD_ADD_CMD  = 2'd1;
   localparam logic [1:0] CMD_FRAME    = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_INSERT  = 3'd0;
   localparam logic [2:0] KIND_MSG     = 3'd1;
   localparam logic [2:0] KIND_CMD     = 3'd2;
   localparam logic [2:0] KIND_ACK     = 3'd3;
   localparam logic [2:0] KIND_DONE    = 3'd4;
   localparam logic [2:0] KIND_DROPPED = 3'd5;

   // register indexes
   localparam logic [1:0] REG_OWN_SYS   = 2'd0;
   localparam logic [1:0] REG_CMD_FRAME = 2'd1;
   localparam logic [1:0] REG_MSG_LIMIT = 2'd2;
   localparam logic [1:0] REG_CMD_LIMIT = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] key_id;
      logic [7:0]  filter_system;
      logic [7:0]  filter_component;
      logic [7:0]  filter_dest_component;
      logic [7:0]  handler_tag;
      logic [7:0]  frame_msg_id;
      logic [7:0]  sender_system;
      logic [7:0]  sender_component;
      logic [15:0] command_number;
      logic [7:0]  dest_system;
      logic [7:0]  dest_component;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        ok;
      logic [7:0]  matched_tag;
      logic [4:0]  entry_index;
      logic [15:0] ack_command;
      logic        any_matched;
      logic        last;
   } rsp_word_type;

   // one stored entry; message entries leave tgt unused and id[15:8] zero
   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  sys;
      logic [7:0]  comp;
      logic [7:0]  tgt;
      logic [7:0]  tag;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request word
      logic sel_cmd;   // operate on command table
      logic rd;        // issue read at pointer
      logic wr_shift;  // write last read entry at pointer+1
      logic wr_new;    // write new entry at pointer
      logic ptr_dec;
      logic ptr_inc;
      logic ptr_zero;
      logic ptr_count; // pointer := count of the table the insert targets
      logic cnt_inc;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       msg_full;
      logic       cmd_full;
      logic       ptr_at_zero;
      logic       ptr_at_end;   // pointer == count
      logic       rd_greater;   // registered entry id > key
      logic       rd_match;     // registered entry matches frame
      logic       is_cmd_frame;
      logic       cmd_drop;
      logic       msg_drop;
      logic       own_sender;
      logic [1:0] command;
   } dp_status_type;

endpackage

// ===== design/sorted_message_filter_dispatch.sv =====
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | smfd_pkg::req_word_type
// rsp     | out       | rsp_valid/rsp_stall | smfd_pkg::rsp_word_type
// csr     | in        | csr_write           | csr_index, csr_data
// One item at a time; the next request word is taken only in the idle state.
// An insert works from the end of its table toward slot zero, with a read, a
// compare and a write per entry moved.
// Reset (synchronous) empties both tables by clearing the fill counts.
// A stalled result word holds the sequencer in its output state; req_stall is
// high whenever an item is in progress.
module sorted_message_filter_dispatch #(
   parameter int MSG_TABLE_DEPTH = smfd_pkg::MSG_DEPTH_DEFAULT,
   parameter int CMD_TABLE_DEPTH = smfd_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  smfd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output smfd_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [16:0]            csr_data
);
   import smfd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [7:0]    rd_tag;
   logic [4:0]    ptr_index;
   logic [15:0]   req_cmd_num;

   smfd_datapath #(.MSG_DEPTH(MSG_TABLE_DEPTH), .CMD_DEPTH(CMD_TABLE_DEPTH)) u_dp (
      .clock, .reset, .req_word, .csr_write, .csr_index, .csr_data,
      .cmd, .status, .rd_tag, .ptr_index, .req_cmd_num
   );

   smfd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .rsp_word, .cmd, .status, .rd_tag, .ptr_index, .req_cmd_num
   );

endmodule

// ===== design/smfd_datapath.sv =====
module smfd_datapath #(
   parameter int MSG_DEPTH = 32,
   parameter int CMD_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smfd_pkg::req_word_type req_word,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [16:0]           csr_data,
   input  smfd_pkg::dp_cmd_type  cmd,
   output smfd_pkg::dp_status_type status,
   output logic [7:0]            rd_tag,
   output logic [4:0]            ptr_index,
   output logic [15:0]           req_cmd_num
);
   import smfd_pkg::*;

   localparam int MW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
   localparam int CW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int PW = 6;

   entry_type msg_mem [MSG_DEPTH];
   entry_type cmd_mem [CMD_DEPTH];

   req_word_type word_ff;
   logic [7:0]  own_ff, cfid_ff;
   logic [8:0]  mlim_ff;
   logic [16:0] clim_ff;
   logic [PW-1:0] mcnt_ff, ccnt_ff, ptr_ff, ptr_in;
   entry_type mrd_ff, crd_ff, rd_e;
   logic [PW-1:0] ptr_p1;
   entry_type new_e;
   logic fs, fc, ft;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff  <= 8'd1;
         cfid_ff <= 8'd76;
         mlim_ff <= 9'd256;
         clim_ff <= 17'd65536;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_OWN_SYS:   own_ff  <= csr_data[7:0];
            REG_CMD_FRAME: cfid_ff <= csr_data[7:0];
            REG_MSG_LIMIT: mlim_ff <= csr_data[8:0];
            REG_CMD_LIMIT: clim_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) word_ff <= req_word;
   end

   // pointer and fill counts
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_zero) ptr_in = '0;
      else if (cmd.ptr_count) ptr_in = (word_ff.command == CMD_ADD_CMD) ? ccnt_ff : mcnt_ff;
      else if (cmd.ptr_dec) ptr_in = ptr_ff - 1'b1;
      else if (cmd.ptr_inc) ptr_in = ptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         mcnt_ff <= '0;
         ccnt_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         if (cmd.cnt_inc && cmd.sel_cmd) ccnt_ff <= ccnt_ff + 1'b1;
         if (cmd.cnt_inc && !cmd.sel_cmd) mcnt_ff <= mcnt_ff + 1'b1;
      end
   end

   assign ptr_p1 = ptr_ff + 1'b1;

   // new entry from captured word
   always_comb begin
      new_e.id   = cmd.sel_cmd ? word_ff.key_id : {8'd0, word_ff.key_id[7:0]};
      new_e.sys  = word_ff.filter_system;
      new_e.comp = word_ff.filter_component;
      new_e.tgt  = cmd.sel_cmd ? word_ff.filter_dest_component : 8'd0;
      new_e.tag  = word_ff.handler_tag;
   end

   // message table memory
   always_ff @(posedge clock) begin
      if (!cmd.sel_cmd && cmd.wr_shift) msg_mem[ptr_p1[MW-1:0]] <= rd_e;
      else if (!cmd.sel_cmd && cmd.wr_new) msg_mem[ptr_ff[MW-1:0]] <= new_e;
      if (cmd.rd) mrd_ff <= msg_mem[ptr_ff[MW-1:0]];
   end

   // command table memory
   always_ff @(posedge clock) begin
      if (cmd.sel_cmd && cmd.wr_shift) cmd_mem[ptr_p1[CW-1:0]] <= rd_e;
      else if (cmd.sel_cmd && cmd.wr_new) cmd_mem[ptr_ff[CW-1:0]] <= new_e;
      if (cmd.rd) crd_ff <= cmd_mem[ptr_ff[CW-1:0]];
   end

   assign rd_e = cmd.sel_cmd ? crd_ff : mrd_ff;

   // read data lags pointer by one; status compares use registered read
   assign fs = (rd_e.sys == 8'd0) || (rd_e.sys == word_ff.sender_system);
   assign fc = (rd_e.comp == 8'd0) || (rd_e.comp == word_ff.sender_component);
   assign ft = (rd_e.tgt == 8'd0) || (rd_e.tgt == word_ff.dest_component);

   always_comb begin
      status.command     = word_ff.command;
      status.msg_full    = (mcnt_ff >= PW'(MSG_DEPTH));
      status.cmd_full    = (ccnt_ff >= PW'(CMD_DEPTH));
      status.ptr_at_zero = (ptr_ff == '0);
      status.ptr_at_end  = (ptr_ff == (cmd.sel_cmd ? ccnt_ff : mcnt_ff));
      status.rd_greater  = cmd.sel_cmd ? (rd_e.id > word_ff.key_id)
                                       : (rd_e.id[7:0] > word_ff.key_id[7:0]);
      status.is_cmd_frame = (word_ff.frame_msg_id == cfid_ff);
      status.cmd_drop    = ({1'b0, word_ff.command_number} >= clim_ff)
                           || !((word_ff.dest_system == own_ff)
                           || (word_ff.dest_system == 8'd0));
      status.msg_drop    = ({1'b0, word_ff.frame_msg_id} >= mlim_ff);
      status.own_sender  = (word_ff.sender_system == own_ff);
      status.rd_match    = cmd.sel_cmd
                           ? ((rd_e.id == word_ff.command_number) && fs && fc && ft)
                           : ((rd_e.id[7:0] == word_ff.frame_msg_id) && fs && fc);
   end

   assign rd_tag      = rd_e.tag;
   assign ptr_index   = 5'(ptr_ff - 1'b1);
   assign req_cmd_num = word_ff.command_number;

endmodule

// ===== design/smfd_ctrl.sv =====
module smfd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output smfd_pkg::rsp_word_type  rsp_word,
   output smfd_pkg::dp_cmd_type    cmd,
   input  smfd_pkg::dp_status_type status,
   input  logic [7:0]              rd_tag,
   input  logic [4:0]              ptr_index,
   input  logic [15:0]             req_cmd_num
);
   import smfd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DEC   = 3'd1;
   localparam logic [2:0] ST_INS_R = 3'd2;  // stop at slot zero, else step pointer down
   localparam logic [2:0] ST_INS_C = 3'd3;  // read issued at the decremented pointer
   localparam logic [2:0] ST_SCAN  = 3'd4;  // read issued, pointer advanced
   localparam logic [2:0] ST_SCAN_C = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;
   localparam logic [2:0] ST_TEST  = 3'd7;  // scan test of the read entry

   logic [2:0] state_ff, state_in;
   logic sel_ff, sel_in, any_ff, any_in, fin_ff, fin_in;
   logic ov_ff, ov_in;
   rsp_word_type ow_ff, ow_in;
   rsp_word_type pw_ff, pw_in;  // next result word, staged until the output is free

   assign rsp_valid = ov_ff;
   assign rsp_word  = ow_ff;
   assign req_stall = (state_ff != ST_IDLE);

   function automatic rsp_word_type mk(input logic [2:0] k, input logic okv,
                                       input logic [7:0] t, input logic [4:0] ix,
                                       input logic [15:0] a, input logic am,
                                       input logic ls);
      rsp_word_type r;
      r.kind = k; r.ok = okv; r.matched_tag = t; r.entry_index = ix;
      r.ack_command = a; r.any_matched = am; r.last = ls;
      return r;
   endfunction

   always_comb begin
      logic free;
      logic full;
      free     = !ov_ff || !rsp_stall;
      full     = (status.command == CMD_ADD_CMD) ? status.cmd_full : status.msg_full;
      state_in = state_ff;
      sel_in   = sel_ff;
      any_in   = any_ff;
      fin_in   = fin_ff;
      ov_in    = ov_ff && rsp_stall;
      ow_in    = ow_ff;
      pw_in    = pw_ff;
      cmd      = '0;
      cmd.sel_cmd = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            sel_in = (status.command == CMD_ADD_CMD) ||
                     ((status.command == CMD_FRAME) && status.is_cmd_frame);
            any_in = 1'b0;
            if (status.command == CMD_ADD_MSG || status.command == CMD_ADD_CMD) begin
               if (full) begin
                  pw_in = mk(KIND_INSERT, 1'b0, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
                  state_in = ST_OUT;
               end else begin
                  cmd.ptr_count = 1'b1;
                  state_in = ST_INS_R;
               end
            end else if (status.command != CMD_FRAME ||
                         (sel_in && status.cmd_drop) ||
                         (!sel_in && status.msg_drop)) begin
               pw_in = mk(KIND_DROPPED, 1'b0, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
               state_in = ST_OUT;
            end else begin
               cmd.ptr_zero = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_INS_R: begin
            if (status.ptr_at_zero) begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               pw_in = mk(KIND_INSERT, 1'b1, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
               state_in = ST_OUT;
            end else begin
               cmd.ptr_dec = 1'b1;
               state_in = ST_INS_C;
            end
         end
         ST_INS_C: begin
            // pointer now j-1; read it this cycle, compare next
            cmd.rd = 1'b1;
            state_in = ST_SCAN_C;
         end
         ST_SCAN_C: begin
            // insert compare phase; pointer = j-1, data valid
            if (status.rd_greater) begin
               cmd.wr_shift = 1'b1;
               state_in = ST_INS_R;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in = ST_INS_R;
               fin_in = 1'b1;
            end
         end
         ST_SCAN: begin
            // frame scan: read entry at pointer, then test
            if (status.ptr_at_end || status.own_sender) begin
               pw_in = sel_ff ? mk(KIND_ACK, 1'b0, 8'd0, 5'd0, req_cmd_num, any_ff, 1'b1)
                              : mk(KIND_DONE, 1'b0, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
               state_in = ST_OUT;
            end else begin
               cmd.rd      = 1'b1;
               cmd.ptr_inc = 1'b1;
               state_in = ST_TEST;
            end
         end
         ST_OUT: begin
            if (free) begin
               ov_in = 1'b1;
               ow_in = pw_ff;
               state_in = pw_ff.last ? ST_IDLE : ST_SCAN;
            end
         end
         ST_TEST: begin
            // scan test: data for entry pointer-1 is valid
            if (status.rd_match) begin
               any_in = 1'b1;
               pw_in = mk(sel_ff ? KIND_CMD : KIND_MSG, 1'b0, rd_tag, ptr_index,
                          16'd0, 1'b0, 1'b0);
               state_in = ST_OUT;
            end else begin
               state_in = ST_SCAN;
            end
         end
      endcase
      // insert path: pointer restored to slot j after a stop
      if (state_ff == ST_INS_R && fin_ff) begin
         cmd = '0;
         cmd.sel_cmd = sel_ff;
         cmd.wr_new  = 1'b1;
         cmd.cnt_inc = 1'b1;
         fin_in = 1'b0;
         pw_in = mk(KIND_INSERT, 1'b1, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
         state_in = ST_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
         sel_ff   <= 1'b0;
         any_ff   <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         sel_ff   <= sel_in;
         any_ff   <= any_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      ow_ff <= ow_in;
      pw_ff <= pw_in;
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import smfd_pkg::*;

   // filter tables and dispatch predictor; holds expected result words in order
   class filter_scoreboard;
      entry_type   msg_tab[32];
      int          msg_cnt;
      entry_type   cmd_tab[32];
      int          cmd_cnt;
      logic [7:0]  own_sys;
      logic [7:0]  cmd_frame;
      logic [8:0]  msg_limit;
      logic [16:0] cmd_limit;
      rsp_word_type pending[$];
      int          errors;

      function new();
         msg_cnt = 0;
         cmd_cnt = 0;
         own_sys = 8'd1;
         cmd_frame = 8'd76;
         msg_limit = 9'd256;
         cmd_limit = 17'd65536;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [16:0] val);
         case (idx)
            REG_OWN_SYS:   own_sys = val[7:0];
            REG_CMD_FRAME: cmd_frame = val[7:0];
            REG_MSG_LIMIT: msg_limit = val[8:0];
            default:       cmd_limit = val;
         endcase
      endfunction

      function void push(logic [2:0] kind, logic ok, logic [7:0] tag, logic [4:0] idx,
                         logic [15:0] ackc, logic anym, logic last);
         rsp_word_type r;
         r.kind = kind;
         r.ok = ok;
         r.matched_tag = tag;
         r.entry_index = idx;
         r.ack_command = ackc;
         r.any_matched = anym;
         r.last = last;
         pending.push_back(r);
      endfunction

      // accepted request word: update tables and queue its results
      function void note_request(req_word_type w);
         entry_type e;
         int j;
         logic any;
         e.id = (w.command == CMD_ADD_MSG) ? {8'd0, w.key_id[7:0]} : w.key_id;
         e.sys = w.filter_system;
         e.comp = w.filter_component;
         e.tgt = (w.command == CMD_ADD_MSG) ? 8'd0 : w.filter_dest_component;
         e.tag = w.handler_tag;
         any = 1'b0;
         if (w.command == CMD_ADD_MSG) begin
            if (msg_cnt >= 32) begin
               push(KIND_INSERT, 1'b0, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
            end else begin
               j = msg_cnt;
               while (j > 0 && msg_tab[j-1].id > e.id) begin
                  msg_tab[j] = msg_tab[j-1];
                  j--;
               end
               msg_tab[j] = e;
               msg_cnt++;
               push(KIND_INSERT, 1'b1, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
            end
         end else if (w.command == CMD_ADD_CMD) begin
            if (cmd_cnt >= 32) begin
               push(KIND_INSERT, 1'b0, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
            end else begin
               j = cmd_cnt;
               while (j > 0 && cmd_tab[j-1].id > e.id) begin
                  cmd_tab[j] = cmd_tab[j-1];
                  j--;
               end
               cmd_tab[j] = e;
               cmd_cnt++;
               push(KIND_INSERT, 1'b1, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
            end
         end else if (w.command != CMD_FRAME) begin
            push(KIND_DROPPED, 1'b0, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
         end else if (w.frame_msg_id == cmd_frame) begin
            if ({1'b0, w.command_number} >= cmd_limit ||
                !(w.dest_system == own_sys || w.dest_system == 8'd0)) begin
               push(KIND_DROPPED, 1'b0, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
            end else begin
               if (w.sender_system != own_sys)
                  for (int i = 0; i < cmd_cnt; i++)
                     if (cmd_tab[i].id == w.command_number &&
                         (cmd_tab[i].sys == 0 || cmd_tab[i].sys == w.sender_system) &&
                         (cmd_tab[i].comp == 0 || cmd_tab[i].comp == w.sender_component) &&
                         (cmd_tab[i].tgt == 0 || cmd_tab[i].tgt == w.dest_component)) begin
                        push(KIND_CMD, 1'b0, cmd_tab[i].tag, i[4:0], 16'd0, 1'b0, 1'b0);
                        any = 1'b1;
                     end
               push(KIND_ACK, 1'b0, 8'd0, 5'd0, w.command_number, any, 1'b1);
            end
         end else if ({1'b0, w.frame_msg_id} >= msg_limit) begin
            push(KIND_DROPPED, 1'b0, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
         end else begin
            if (w.sender_system != own_sys)
               for (int i = 0; i < msg_cnt; i++)
                  if (msg_tab[i].id[7:0] == w.frame_msg_id &&
                      (msg_tab[i].sys == 0 || msg_tab[i].sys == w.sender_system) &&
                      (msg_tab[i].comp == 0 || msg_tab[i].comp == w.sender_component))
                     push(KIND_MSG, 1'b0, msg_tab[i].tag, i[4:0], 16'd0, 1'b0, 1'b0);
            push(KIND_DONE, 1'b0, 8'd0, 5'd0, 16'd0, 1'b0, 1'b1);
         end
      endfunction

      // accepted result word against the oldest expectation
      function void check_result(rsp_word_type got);
         rsp_word_type exp_w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         exp_w = pending.pop_front();
         if (got.kind !== exp_w.kind || got.ok !== exp_w.ok ||
             got.matched_tag !== exp_w.matched_tag ||
             got.entry_index !== exp_w.entry_index ||
             got.ack_command !== exp_w.ack_command ||
             got.any_matched !== exp_w.any_matched || got.last !== exp_w.last) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_w, got);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   rsp_word_type rsp_word;
   logic         csr_write = 0;
   logic [1:0]   csr_index = '0;
   logic [16:0]  csr_data = '0;

   filter_scoreboard board = new();
   longint       cycles = 0;
   bit           stim_done = 0;
   bit           hold_rsp = 0;
   logic [7:0]   hot_ids[4];
   logic [15:0]  hot_cmds[4];

   sorted_message_filter_dispatch i_dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random stalls, check on accept
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_word);
   end

   initial begin
      int gap;
      forever begin
         @(posedge clock);
         gap = hold_rsp ? $urandom_range(0, 14) : 0;
         if (gap != 0) begin
            rsp_stall <= 1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 0;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [16:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      board.set_reg(idx, val);
      @(posedge clock);
   endtask

   // wait until every expected word has come, then let the block settle
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // valid stays high after acceptance; the block stalls while it works
   task automatic send_word(req_word_type w, bit pace);
      int gap;
      gap = pace ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(w);
   endtask

   function automatic req_word_type rand_word();
      logic [127:0] r;
      r = {$urandom, $urandom, $urandom, $urandom};
      return r[$bits(req_word_type)-1:0];
   endfunction

   function automatic req_word_type make_add(logic [1:0] c, logic [15:0] k,
                                             logic [7:0] s, logic [7:0] cp,
                                             logic [7:0] t, logic [7:0] tag);
      req_word_type w;
      w = rand_word();
      w.command = c;
      w.key_id = k;
      w.filter_system = s;
      w.filter_component = cp;
      w.filter_dest_component = t;
      w.handler_tag = tag;
      return w;
   endfunction

   function automatic req_word_type make_frame(logic [7:0] mid, logic [7:0] ss,
                                               logic [7:0] sc, logic [15:0] cn,
                                               logic [7:0] ts, logic [7:0] tc);
      req_word_type w;
      w = rand_word();
      w.command = CMD_FRAME;
      w.frame_msg_id = mid;
      w.sender_system = ss;
      w.sender_component = sc;
      w.command_number = cn;
      w.dest_system = ts;
      w.dest_component = tc;
      return w;
   endfunction

   // random word biased toward hot ids and matching senders
   function automatic req_word_type pick_word();
      req_word_type w;
      int r;
      r = $urandom_range(0, 99);
      w = rand_word();
      if (r < 15) begin
         w = make_add(CMD_ADD_MSG,
                      {8'($urandom_range(0, 255)), hot_ids[$urandom_range(0, 3)]},
                      ($urandom_range(0, 1) ? 8'd0 : 8'd5),
                      ($urandom_range(0, 1) ? 8'd0 : 8'd7), 8'($urandom), 8'($urandom));
      end else if (r < 30) begin
         w = make_add(CMD_ADD_CMD, hot_cmds[$urandom_range(0, 3)],
                      ($urandom_range(0, 1) ? 8'd0 : 8'd5),
                      ($urandom_range(0, 1) ? 8'd0 : 8'd7),
                      ($urandom_range(0, 1) ? 8'd0 : 8'd9), 8'($urandom));
      end else if (r < 55) begin
         w = make_frame(hot_ids[$urandom_range(0, 3)],
                        ($urandom_range(0, 3) != 0 ? 8'd5 : board.own_sys),
                        ($urandom_range(0, 2) != 0 ? 8'd7 : 8'($urandom)),
                        16'($urandom), 8'($urandom), 8'($urandom));
      end else if (r < 85) begin
         w = make_frame(board.cmd_frame,
                        ($urandom_range(0, 3) != 0 ? 8'd5 : board.own_sys),
                        ($urandom_range(0, 2) != 0 ? 8'd7 : 8'($urandom)),
                        hot_cmds[$urandom_range(0, 3)],
                        ($urandom_range(0, 3) == 0 ? 8'($urandom) :
                         ($urandom_range(0, 1) ? 8'd0 : board.own_sys)),
                        ($urandom_range(0, 2) != 0 ? 8'd9 : 8'($urandom)));
      end else if (r < 92) begin
         w.command = CMD_RESERVED;
      end
      return w;
   endfunction

   initial begin
      hot_ids = '{8'd0, 8'd10, 8'd76, 8'd255};
      hot_cmds = '{16'd0, 16'd400, 16'd65535, 16'd400};
      hold_rsp = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty scans, inserts with equal ids, matches, drops
      send_word(make_frame(8'd10, 8'd5, 8'd7, 16'd0, 8'd0, 8'd0), 0);
      send_word(make_frame(8'd76, 8'd5, 8'd7, 16'd400, 8'd0, 8'd9), 0);
      send_word(make_add(CMD_ADD_MSG, 16'hFF0A, 8'd0, 8'd0, 8'd0, 8'hFF), 0);
      send_word(make_add(CMD_ADD_MSG, 16'h000A, 8'd5, 8'd7, 8'd0, 8'h01), 0);
      send_word(make_add(CMD_ADD_MSG, 16'h0000, 8'hFF, 8'hFF, 8'd0, 8'h02), 0);
      send_word(make_add(CMD_ADD_MSG, 16'h00FF, 8'd0, 8'd0, 8'd0, 8'h03), 0);
      send_word(make_add(CMD_ADD_CMD, 16'd400, 8'd0, 8'd0, 8'd0, 8'h10), 0);
      send_word(make_add(CMD_ADD_CMD, 16'd400, 8'd5, 8'd7, 8'd9, 8'h11), 0);
      send_word(make_add(CMD_ADD_CMD, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h12), 0);
      send_word(make_add(CMD_ADD_CMD, 16'd0, 8'd0, 8'd0, 8'd0, 8'h13), 0);
      send_word(make_frame(8'd10, 8'd5, 8'd7, 16'd0, 8'd0, 8'd0), 0);
      send_word(make_frame(8'd10, 8'd1, 8'd7, 16'd0, 8'd0, 8'd0), 0);
      send_word(make_frame(8'd255, 8'd5, 8'd7, 16'd0, 8'd0, 8'd0), 0);
      send_word(make_frame(8'd76, 8'd5, 8'd7, 16'd400, 8'd1, 8'd9), 0);
      send_word(make_frame(8'd76, 8'd1, 8'd7, 16'd400, 8'd0, 8'd9), 0);
      send_word(make_frame(8'd76, 8'd5, 8'd7, 16'd400, 8'd3, 8'd9), 0);
      send_word(make_frame(8'd76, 8'hFF, 8'hFF, 16'hFFFF, 8'd0, 8'hFF), 0);
      send_word(make_frame(8'd76, 8'd5, 8'd7, 16'd401, 8'd0, 8'd9), 0);
      begin
         req_word_type w;
         w = rand_word();
         w.command = CMD_RESERVED;
         send_word(w, 0);
      end
      drain();

      // tighter limits and another own id
      write_reg(REG_OWN_SYS, 17'd255);
      write_reg(REG_CMD_FRAME, 17'd10);
      write_reg(REG_MSG_LIMIT, 17'd255);
      write_reg(REG_CMD_LIMIT, 17'd400);
      send_word(make_frame(8'd255, 8'd5, 8'd7, 16'd0, 8'd0, 8'd0), 0);
      send_word(make_frame(8'd10, 8'd5, 8'd7, 16'd400, 8'd255, 8'd9), 0);
      send_word(make_frame(8'd10, 8'd5, 8'd7, 16'd0, 8'd255, 8'd9), 0);
      send_word(make_frame(8'd76, 8'd5, 8'd7, 16'd0, 8'd0, 8'd0), 0);

      // random phases under several settings
      hold_rsp = 1;
      for (int p = 0; p < 4; p++) begin
         drain();
         case (p)
            0: begin
               write_reg(REG_OWN_SYS, 17'd0);
               write_reg(REG_CMD_FRAME, 17'd76);
               write_reg(REG_MSG_LIMIT, 17'd256);
               write_reg(REG_CMD_LIMIT, 17'd65536);
            end
            1: begin
               write_reg(REG_MSG_LIMIT, 17'd0);
               write_reg(REG_CMD_LIMIT, 17'd0);
               write_reg(REG_CMD_FRAME, 17'd255);
            end
            2: begin
               write_reg(REG_OWN_SYS, 17'd1);
               write_reg(REG_CMD_FRAME, 17'd0);
               write_reg(REG_MSG_LIMIT, 17'd77);
               write_reg(REG_CMD_LIMIT, 17'd65535);
            end
            default: begin
               write_reg(REG_CMD_FRAME, 17'd76);
               write_reg(REG_MSG_LIMIT, 17'd256);
               write_reg(REG_CMD_LIMIT, 17'd65536);
            end
         endcase
         for (int n = 0; n < 72; n++) begin
            send_word(pick_word(), (n % 24) >= 8);
            if (n == 40) begin
               // sender holds off until everything is out
               req_valid <= 0;
               while (board.pending.size() != 0) @(posedge clock);
               @(posedge clock);
            end
         end
      end
      req_valid <= 0;
      stim_done = 1;
   end

   // end of run
   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// ===== sorted_message_filter_dispatch.f =====
design/smfd_pkg.sv
design/smfd_datapath.sv
design/smfd_ctrl.sv
design/sorted_message_filter_dispatch.sv
test/testbench.sv
